// ===== design/rnth_pkg.sv =====
package rnth_pkg;

  localparam logic [7:0] TYPE_VALIDATE  = 8'h31;
  localparam logic [7:0] TYPE_DISCOVER  = 8'h32;
  localparam logic [7:0] TYPE_PUBLISH   = 8'h33;
  localparam logic [7:0] TYPE_PING      = 8'h34;
  localparam logic [7:0] TYPE_PING_ACK  = 8'h35;
  localparam logic [7:0] TYPE_CLEAR     = 8'h38;
  localparam logic [7:0] TYPE_VALID_ACK = 8'h39;
  localparam logic [7:0] TYPE_TEXT      = 8'h61;

  localparam logic [7:0]  CHAR_ONE    = 8'd49;
  localparam logic [7:0]  COUNT_BASE  = 8'd96;
  localparam logic [31:0] REEN_BYTES  = 32'h6E65_6572;
  localparam logic [7:0]  ROOT_RESET  = 8'd97;
  localparam logic [7:0]  CLEAR_RESET = 8'd120;

  localparam logic [2:0] OP_PACKET   = 3'd0;
  localparam logic [2:0] OP_VALIDATE = 3'd1;
  localparam logic [2:0] OP_DISCOVER = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_PING     = 3'd4;
  localparam logic [2:0] OP_TEXT     = 3'd5;

  localparam logic CFG_ROOT  = 1'b0;
  localparam logic CFG_CLEAR = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  pkt_type;
    logic [63:0] content_lo;
    logic [39:0] content_hi;
    logic [7:0]  org;
    logic [7:0]  dest;
  } in_word_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  out_type;
    logic [63:0] out_content_lo;
    logic [39:0] out_content_hi;
    logic [7:0]  out_org;
    logic [7:0]  out_dest;
    logic [7:0]  node_address;
    logic [7:0]  node_count;
    logic        validated;
    logic        ping_found;
    logic [7:0]  parts_expected;
  } out_word_t;

endpackage

// ===== design/rnth_if.sv =====
interface rnth_in_if;
  logic                valid;
  logic                ready;
  rnth_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rnth_out_if;
  logic                valid;
  logic                ready;
  rnth_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ring_node_token_handler_core.sv =====
// Token ring node: every accepted word yields one registered result word in the cycle after.
// Throughput is one word per cycle while the sink is ready; the single output
// register holds a result while the sink stalls, and a new word is taken in
// the cycle the result leaves. Reset (synchronous, active high) clears the node
// state and the output valid, and sets the root and clear addresses to 97 and 120.
module ring_node_token_handler_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  rnth_in_if.sink    in_ch,
  rnth_out_if.source out_ch
);
  import rnth_pkg::*;

  logic [7:0] root_address;
  logic [7:0] clear_address;
  logic [7:0] own_address;
  logic [7:0] known_nodes;
  logic       ring_valid;
  logic       ping_flag;
  logic [7:0] text_parts;

  logic [7:0] own_address_next;
  logic [7:0] known_nodes_next;
  logic       ring_valid_next;
  logic       ping_flag_next;
  logic [7:0] text_parts_next;

  out_word_t  result;
  out_word_t  result_next;
  logic       result_valid;
  logic       accept;

  assign in_ch.ready  = !result_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = result_valid;
  assign out_ch.data  = result;

  always_comb begin
    logic [7:0]  c0;
    logic        owned;
    logic [63:0] lo;
    logic [39:0] hi;
    logic [7:0]  o;
    logic [7:0]  d;
    c0 = in_ch.data.content_lo[7:0];
    lo = in_ch.data.content_lo;
    hi = in_ch.data.content_hi;
    o  = in_ch.data.org;
    d  = in_ch.data.dest;
    owned = (d == own_address);

    own_address_next = own_address;
    known_nodes_next = known_nodes;
    ring_valid_next  = ring_valid;
    ping_flag_next   = ping_flag;
    text_parts_next  = text_parts;
    result_next      = '0;

    case (in_ch.data.operation)
      OP_PACKET: begin
        case (in_ch.data.pkt_type)
          TYPE_VALIDATE: begin
            result_next.send_valid = 1'b1;
            if (owned) begin
              ring_valid_next = 1'b1;
              result_next.out_type       = TYPE_VALID_ACK;
              result_next.out_content_lo = {56'd0, CHAR_ONE};
              result_next.out_org        = own_address;
              result_next.out_dest       = own_address;
            end else begin
              own_address_next = 8'd0;
              result_next.out_type       = TYPE_VALIDATE;
              result_next.out_content_lo = {lo[63:40], 8'd0, REEN_BYTES};
              result_next.out_content_hi = hi;
              result_next.out_org        = o;
              result_next.out_dest       = d;
            end
          end
          TYPE_DISCOVER: begin
            result_next.send_valid = 1'b1;
            if (!owned) begin
              own_address_next = c0 + 8'd1;
              result_next.out_type       = TYPE_DISCOVER;
              result_next.out_content_lo = {lo[63:16], 8'd0, c0 + 8'd1};
              result_next.out_content_hi = hi;
              result_next.out_org        = o;
              result_next.out_dest       = d;
            end else begin
              known_nodes_next = c0 - COUNT_BASE;
              result_next.out_type       = TYPE_PUBLISH;
              result_next.out_content_lo = {56'd0, c0};
              result_next.out_org        = own_address;
              result_next.out_dest       = own_address;
            end
          end
          TYPE_PUBLISH: begin
            if (!owned) begin
              known_nodes_next = c0 - COUNT_BASE;
              result_next.send_valid     = 1'b1;
              result_next.out_type       = TYPE_PUBLISH;
              result_next.out_content_lo = lo;
              result_next.out_content_hi = hi;
              result_next.out_org        = o;
              result_next.out_dest       = d;
            end
          end
          TYPE_PING: begin
            if (owned) begin
              result_next.send_valid     = 1'b1;
              result_next.out_type       = TYPE_PING_ACK;
              result_next.out_content_lo = {56'd0, CHAR_ONE};
              result_next.out_org        = own_address;
              result_next.out_dest       = o;
            end else if (o != own_address) begin
              result_next.send_valid     = 1'b1;
              result_next.out_type       = TYPE_PING;
              result_next.out_content_lo = lo;
              result_next.out_content_hi = hi;
              result_next.out_org        = o;
              result_next.out_dest       = d;
            end
          end
          TYPE_PING_ACK: begin
            if (owned) begin
              ping_flag_next = (c0 == CHAR_ONE);
            end else begin
              result_next.send_valid     = 1'b1;
              result_next.out_type       = TYPE_PING_ACK;
              result_next.out_content_lo = lo;
              result_next.out_content_hi = hi;
              result_next.out_org        = o;
              result_next.out_dest       = d;
            end
          end
          TYPE_CLEAR: begin
            if (!owned) begin
              own_address_next = 8'd0;
              result_next.send_valid     = 1'b1;
              result_next.out_type       = TYPE_CLEAR;
              result_next.out_content_lo = lo;
              result_next.out_content_hi = hi;
              result_next.out_org        = o;
              result_next.out_dest       = d;
            end
          end
          TYPE_VALID_ACK: begin
            if (c0 == CHAR_ONE) begin
              ring_valid_next = 1'b1;
            end
            if (!owned) begin
              result_next.send_valid     = 1'b1;
              result_next.out_type       = TYPE_VALID_ACK;
              result_next.out_content_lo = lo;
              result_next.out_content_hi = hi;
              result_next.out_org        = o;
              result_next.out_dest       = d;
            end
          end
          TYPE_TEXT: begin
            text_parts_next = c0;
          end
          default: begin
          end
        endcase
      end
      OP_VALIDATE: begin
        own_address_next = root_address;
        known_nodes_next = 8'd0;
        ring_valid_next  = 1'b0;
        result_next.send_valid = 1'b1;
        result_next.out_type   = TYPE_VALIDATE;
        result_next.out_org    = root_address;
        result_next.out_dest   = root_address;
      end
      OP_DISCOVER: begin
        result_next.send_valid     = 1'b1;
        result_next.out_type       = TYPE_DISCOVER;
        result_next.out_content_lo = {56'd0, root_address};
        result_next.out_org        = root_address;
        result_next.out_dest       = root_address;
      end
      OP_CLEAR: begin
        own_address_next = clear_address;
        result_next.send_valid = 1'b1;
        result_next.out_type   = TYPE_CLEAR;
        result_next.out_org    = clear_address;
        result_next.out_dest   = clear_address;
      end
      OP_PING: begin
        ping_flag_next = 1'b0;
        result_next.send_valid = 1'b1;
        result_next.out_type   = TYPE_PING;
        result_next.out_org    = own_address;
        result_next.out_dest   = d;
      end
      OP_TEXT: begin
        result_next.send_valid     = 1'b1;
        result_next.out_type       = TYPE_TEXT;
        result_next.out_content_lo = {56'd0, c0};
        result_next.out_org        = own_address;
        result_next.out_dest       = own_address;
      end
      default: begin
      end
    endcase

    result_next.node_address   = own_address_next;
    result_next.node_count     = known_nodes_next;
    result_next.validated      = ring_valid_next;
    result_next.ping_found     = ping_flag_next;
    result_next.parts_expected = text_parts_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_address  <= ROOT_RESET;
      clear_address <= CLEAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT:  root_address  <= cfg_data;
        CFG_CLEAR: clear_address <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= 8'd0;
      known_nodes  <= 8'd0;
      ring_valid   <= 1'b0;
      ping_flag    <= 1'b0;
      text_parts   <= 8'd0;
      result_valid <= 1'b0;
    end else if (accept) begin
      own_address  <= own_address_next;
      known_nodes  <= known_nodes_next;
      ring_valid   <= ring_valid_next;
      ping_flag    <= ping_flag_next;
      text_parts   <= text_parts_next;
      result_valid <= 1'b1;
    end else if (out_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule
